// ----- src/lmfs_pkg.sv -----
package lmfs_pkg;

  localparam int MAX_DEVICES = 4;
  localparam int NUM_COLS    = MAX_DEVICES * 8;
  localparam int IDX_W       = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int ADDR_W      = IDX_W + 3;
  localparam int CNT_W       = $clog2(MAX_DEVICES + 1);
  localparam int COL_W       = 8;
  localparam int WORD_W      = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 3;

  localparam logic [7:0] ROW_BASE = 8'h01;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_DEVICES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_MODE    = 1'd1;

  typedef enum logic [2:0] {
    OP_CLEAR     = 3'd0,
    OP_WRITE_COL = 3'd1,
    OP_SET_PIXEL = 3'd2,
    OP_COMMIT    = 3'd3,
    OP_REG_ONE   = 3'd4,
    OP_REG_ALL   = 3'd5
  } op_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    logic [COL_W-1:0]  wr_data;
    logic              clr_en;
    logic [CNT_W-1:0]  clr_count;
  } store_req_t;

endpackage

// ----- src/led_matrix_frame_serializer_unit.sv -----
// Channel | Handshake               | Payload
// in_     | in_tvalid / in_tready   | tdata: position, pixel_row, value, device, reg_addr; tuser: op
// out_    | out_tvalid / out_tready | tdata: spi_word; tuser: frame_end; tlast: last
// cfg_    | cfg_valid / cfg_ready   | cfg_index, cfg_data (active_devices, rotate_mode)
//
// Clear and normal column write act on acceptance. Set pixel: a store read, then a write back.
// Rotated write: read, write back per bit. Commit: per word a store read, then an output load.
// Register writes: one word per cycle while the output is not stalled, n words for one device, n*n for all.
// Sync reset clears the column store valid bits at once; no clearing pass.
// A stalled output holds the sequencer in its emit step; cfg_ready is always high.
module led_matrix_frame_serializer_unit
  import lmfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,   // position[4:0] pixel_row[7:5] value[15:8]
                                            // device[17:16] reg_addr[21:18] zero[23:22]
  input  logic [2:0]            in_tuser,   // op[2:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [WORD_W-1:0]     out_tdata,  // spi_word[15:0]
  output logic [0:0]            out_tuser,  // frame_end[0]
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [2:0]       active_r;
  logic             rotate_r;
  logic [CNT_W-1:0] dev_n;
  store_req_t       req;
  logic [COL_W-1:0] rd_data;
  logic             fend;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 3'd4;
      rotate_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ACTIVE_DEVICES: active_r <= cfg_data;
        CFG_ROTATE_MODE:    rotate_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (active_r == 3'd0) begin
      dev_n = CNT_W'(1);
    end else if (int'(active_r) > MAX_DEVICES) begin
      dev_n = CNT_W'(MAX_DEVICES);
    end else begin
      dev_n = CNT_W'(active_r);
    end
  end

  lmfs_col_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rd_data)
  );

  lmfs_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_pos    (in_tdata[4:0]),
    .in_row    (in_tdata[7:5]),
    .in_val    (in_tdata[15:8]),
    .in_dev    (in_tdata[17:16]),
    .in_reg    (in_tdata[21:18]),
    .dev_n     (dev_n),
    .rotate    (rotate_r),
    .req       (req),
    .rd_data   (rd_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (out_tdata),
    .out_fend  (fend),
    .out_last  (out_tlast)
  );

  assign out_tuser = fend;

endmodule

// ----- src/lmfs_col_store.sv -----
module lmfs_col_store
  import lmfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  store_req_t       req,
  output logic [COL_W-1:0] rd_data
);

  logic [COL_W-1:0] mem [NUM_COLS];
  logic [NUM_COLS-1:0] valid_r;
  logic [COL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= valid_r[req.addr] ? mem[req.addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.clr_en) begin
      for (int j = 0; j < NUM_COLS; j++) begin
        if ((j >> 3) < int'(req.clr_count)) begin
          valid_r[j] <= 1'b0;
        end
      end
    end else if (req.wr_en) begin
      valid_r[req.addr] <= 1'b1;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/lmfs_sequencer.sv -----
module lmfs_sequencer
  import lmfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_op,
  input  logic [4:0]        in_pos,
  input  logic [2:0]        in_row,
  input  logic [7:0]        in_val,
  input  logic [1:0]        in_dev,
  input  logic [3:0]        in_reg,
  input  logic [CNT_W-1:0]  dev_n,
  input  logic              rotate,
  output store_req_t        req,
  input  logic [COL_W-1:0]  rd_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_word,
  output logic              out_fend,
  output logic              out_last
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_EMIT_RD,
    ST_EMIT
  } state_t;

  state_t            state_r, state_nxt;
  logic              commit_r, commit_nxt;
  logic              single_r, single_nxt;
  logic              rot_r, rot_nxt;
  logic [4:0]        pos_r, pos_nxt;
  logic [7:0]        val_r, val_nxt;
  logic [3:0]        reg_r, reg_nxt;
  logic [7:0]        mask_r, mask_nxt;
  logic [2:0]        bit_r, bit_nxt;
  logic [2:0]        row_r, row_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  tgt_r, tgt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_word_r, out_word_nxt;
  logic              out_fend_r, out_fend_nxt;
  logic              out_last_r, out_last_nxt;

  logic              accept;
  logic              pos_ok;
  logic              dev_ok;
  logic              slot_free;
  logic              load;
  logic [ADDR_W-1:0] rmw_addr;
  logic [7:0]        rmw_or;
  logic [WORD_W-1:0] emit_word;
  logic              emit_fend;
  logic              emit_last;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign pos_ok    = (32'(in_pos) < (32'(dev_n) << 3));
  assign dev_ok    = (32'(in_dev) < 32'(dev_n));
  assign slot_free = !out_valid_r || out_ready;
  assign load      = (state_r == ST_EMIT) && slot_free;

  assign rmw_addr = rot_r ? {IDX_W'(pos_r >> 3), bit_r} : ADDR_W'(pos_r);
  assign rmw_or   = rot_r ? (val_r[bit_r] ? mask_r : 8'h00) : mask_r;

  always_comb begin
    if (commit_r) begin
      emit_word = {ROW_BASE + 8'(row_r), rd_data};
    end else if (idx_r == tgt_r) begin
      emit_word = {4'b0000, reg_r, val_r};
    end else begin
      emit_word = '0;
    end
    emit_fend = ((CNT_W'(idx_r) + CNT_W'(1)) == dev_n);
    if (commit_r) begin
      emit_last = emit_fend && (row_r == 3'd7);
    end else begin
      emit_last = emit_fend && (single_r || ((CNT_W'(tgt_r) + CNT_W'(1)) == dev_n));
    end
  end

  always_comb begin
    state_nxt     = state_r;
    commit_nxt    = commit_r;
    single_nxt    = single_r;
    rot_nxt       = rot_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    reg_nxt       = reg_r;
    mask_nxt      = mask_r;
    bit_nxt       = bit_r;
    row_nxt       = row_r;
    idx_nxt       = idx_r;
    tgt_nxt       = tgt_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    out_fend_nxt  = out_fend_r;
    out_last_nxt  = out_last_r;
    req           = '0;
    req.clr_count = dev_n;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          pos_nxt = in_pos;
          val_nxt = in_val;
          reg_nxt = in_reg;
          bit_nxt = '0;
          row_nxt = '0;
          idx_nxt = '0;
          tgt_nxt = '0;
          case (in_op)
            OP_CLEAR: begin
              req.clr_en = 1'b1;
            end
            OP_WRITE_COL: begin
              if (pos_ok) begin
                if (rotate) begin
                  rot_nxt   = 1'b1;
                  mask_nxt  = 8'h80 >> in_pos[2:0];
                  state_nxt = ST_RMW_RD;
                end else begin
                  req.wr_en   = 1'b1;
                  req.addr    = ADDR_W'(in_pos);
                  req.wr_data = in_val;
                end
              end
            end
            OP_SET_PIXEL: begin
              if (pos_ok) begin
                rot_nxt   = 1'b0;
                mask_nxt  = 8'h01 << in_row;
                state_nxt = ST_RMW_RD;
              end
            end
            OP_COMMIT: begin
              commit_nxt = 1'b1;
              state_nxt  = ST_EMIT_RD;
            end
            OP_REG_ONE: begin
              if (dev_ok) begin
                commit_nxt = 1'b0;
                single_nxt = 1'b1;
                tgt_nxt    = IDX_W'(in_dev);
                state_nxt  = ST_EMIT;
              end
            end
            OP_REG_ALL: begin
              commit_nxt = 1'b0;
              single_nxt = 1'b0;
              state_nxt  = ST_EMIT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RMW_RD: begin
        req.rd_en = 1'b1;
        req.addr  = rmw_addr;
        state_nxt = ST_RMW_WR;
      end
      ST_RMW_WR: begin
        req.wr_en   = 1'b1;
        req.addr    = rmw_addr;
        req.wr_data = rd_data | rmw_or;
        if (!rot_r || bit_r == 3'd7) begin
          state_nxt = ST_IDLE;
        end else begin
          bit_nxt   = bit_r + 3'd1;
          state_nxt = ST_RMW_RD;
        end
      end
      ST_EMIT_RD: begin
        req.rd_en = 1'b1;
        req.addr  = {idx_r, row_r};
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = emit_word;
          out_fend_nxt  = emit_fend;
          out_last_nxt  = emit_last;
          if (emit_fend) begin
            idx_nxt = '0;
            if (commit_r) begin
              row_nxt = row_r + 3'd1;
            end else begin
              tgt_nxt = tgt_r + IDX_W'(1);
            end
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end else if (commit_r) begin
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    commit_r   <= commit_nxt;
    single_r   <= single_nxt;
    rot_r      <= rot_nxt;
    pos_r      <= pos_nxt;
    val_r      <= val_nxt;
    reg_r      <= reg_nxt;
    mask_r     <= mask_nxt;
    bit_r      <= bit_nxt;
    row_r      <= row_nxt;
    idx_r      <= idx_nxt;
    tgt_r      <= tgt_nxt;
    out_word_r <= out_word_nxt;
    out_fend_r <= out_fend_nxt;
    out_last_r <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_fend  = out_fend_r;
  assign out_last  = out_last_r;

  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_fend_r)
    else $error("last word does not end a frame");

  a_last_load_idles: assert property (@(posedge clk) disable iff (!rst_n)
    load && emit_last |=> state_r == ST_IDLE)
    else $error("sequencer busy after last word");

  a_rmw_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RMW_RD |=> state_r == ST_RMW_WR)
    else $error("store read not followed by write back");

  a_store_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.clr_en && (req.wr_en || req.rd_en)))
    else $error("clear collides with store access");

  a_read_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT_RD |=> state_r == ST_EMIT)
    else $error("column read not followed by emit");

endmodule

// ----- test/led_matrix_frame_serializer_unit_tb.sv -----
module led_matrix_frame_serializer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lmfs_pkg::*;

  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;
  localparam int STUCK_LIMIT   = 1000;
  localparam int HOLD_CYCLES   = 200;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 62;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              fend;
    logic              last;
  } spi_beat_t;

  class frame_scoreboard;
    logic [COL_W-1:0] cols [NUM_COLS];
    logic [2:0]       chain_cfg;
    logic             rotated;
    spi_beat_t        pending [$];
    int               errors;
    int               words_seen;
    int               items_seen;

    function new();
      foreach (cols[i]) cols[i] = '0;
      chain_cfg  = 3'd4;
      rotated    = 1'b0;
      errors     = 0;
      words_seen = 0;
      items_seen = 0;
    endfunction

    function int chain_len();
      if (chain_cfg == 0) return 1;
      if (chain_cfg > MAX_DEVICES) return MAX_DEVICES;
      return chain_cfg;
    endfunction

    function void write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_ACTIVE_DEVICES) chain_cfg = data;
      else if (idx == CFG_ROTATE_MODE) rotated = data[0];
    endfunction

    function void queue_frame(int n, int tgt, logic [WORD_W-1:0] word);
      spi_beat_t b;
      for (int i = 0; i < n; i++) begin
        b.word = (i == tgt) ? word : '0;
        b.fend = (i == n - 1);
        b.last = 1'b0;
        pending.push_back(b);
      end
    endfunction

    function void note_input(logic [2:0] op, logic [4:0] pos, logic [2:0] row,
                             logic [7:0] val, logic [1:0] dev, logic [3:0] addr);
      int        n;
      int        ncols;
      int        start;
      int        p;
      spi_beat_t b;
      n     = chain_len();
      ncols = n * 8;
      start = pending.size();
      p     = pos;
      items_seen++;
      case (op)
        OP_CLEAR: begin
          for (int i = 0; i < ncols; i++) cols[i] = '0;
        end
        OP_WRITE_COL: begin
          if (p < ncols) begin
            if (rotated) begin
              for (int i = 0; i < 8; i++)
                if (val[i]) cols[(p / 8) * 8 + i][7 - (p % 8)] = 1'b1;
            end else begin
              cols[p] = val;
            end
          end
        end
        OP_SET_PIXEL: begin
          if (p < ncols) cols[p][row] = 1'b1;
        end
        OP_COMMIT: begin
          for (int r = 0; r < 8; r++) begin
            for (int i = 0; i < n; i++) begin
              b.word = {8'(ROW_BASE + r), cols[i * 8 + r]};
              b.fend = (i == n - 1);
              b.last = 1'b0;
              pending.push_back(b);
            end
          end
        end
        OP_REG_ONE: begin
          if (dev < n) queue_frame(n, dev, {4'b0000, addr, val});
        end
        OP_REG_ALL: begin
          for (int i = 0; i < n; i++) queue_frame(n, i, {4'b0000, addr, val});
        end
        default: ;
      endcase
      if (pending.size() > start) pending[pending.size() - 1].last = 1'b1;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [WORD_W-1:0] word, logic fend, logic last);
      spi_beat_t want;
      words_seen++;
      if (pending.size() == 0) begin
        report($sformatf("word %h arrived with nothing pending", word));
        return;
      end
      want = pending.pop_front();
      if (word !== want.word)
        report($sformatf("spi_word %h, want %h", word, want.word));
      if (fend !== want.fend)
        report($sformatf("frame_end %b, want %b (word %h)", fend, want.fend, want.word));
      if (last !== want.last)
        report($sformatf("last %b, want %b (word %h)", last, want.last, want.word));
    endtask
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [23:0]           in_tdata  = '0;
  logic [2:0]            in_tuser  = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [WORD_W-1:0]     out_tdata;
  logic [0:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  bit tx_gaps   = 1'b0;
  bit rx_stalls = 1'b0;
  bit hold_req  = 1'b0;
  int stuck_cycles = 0;
  int cfg_writes   = 0;

  frame_scoreboard sb = new();

  led_matrix_frame_serializer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        sb.write_cfg(cfg_index, cfg_data);
        cfg_writes++;
      end
      if (in_tvalid && in_tready)
        sb.note_input(in_tuser, in_tdata[4:0], in_tdata[7:5], in_tdata[15:8],
                      in_tdata[17:16], in_tdata[21:18]);
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata, out_tuser[0], out_tlast);
      if ((cfg_valid && cfg_ready) || (in_tvalid && in_tready) ||
          (out_tvalid && out_tready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STUCK_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // receiver: long hold on request, short random stalls when enabled, else always ready
  initial begin
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_item(logic [2:0] op, logic [4:0] pos, logic [2:0] row,
                           logic [7:0] val, logic [1:0] dev, logic [3:0] addr);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, addr, dev, val, row, pos};
    do @(posedge clk); while (!in_tready);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic send_random();
    int         pick;
    int         n;
    logic [2:0] op;
    logic [4:0] pos;
    n    = sb.chain_len();
    pick = $urandom_range(0, 99);
    pos  = ($urandom_range(0, 4) != 0) ? 5'($urandom_range(0, n * 8 - 1))
                                       : 5'($urandom_range(0, 31));
    if (pick < 35)      op = OP_WRITE_COL;
    else if (pick < 55) op = OP_SET_PIXEL;
    else if (pick < 69) op = OP_COMMIT;
    else if (pick < 80) op = OP_REG_ONE;
    else if (pick < 86) op = OP_REG_ALL;
    else if (pick < 90) op = OP_CLEAR;
    else if (pick < 94) op = ($urandom_range(0, 1) != 0) ? OP_RSVD6 : OP_RSVD7;
    else begin
      op  = OP_WRITE_COL;
      pos = 5'($urandom_range(0, 31));
    end
    send_item(op, pos, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
              2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
  endtask

  // drop valid, wait for every pending word, then let in-flight writes finish
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(logic [CFG_DATA_W-1:0] devices, logic rot);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_ACTIVE_DEVICES;
    cfg_data  <= devices;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_ROTATE_MODE;
    cfg_data  <= CFG_DATA_W'(rot);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] phase_dev [PHASES];
    logic                  phase_rot [PHASES];
    bit                    quiet;
    phase_dev = '{3'd4, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd1, 3'd6};
    phase_rot = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_config(3'd4, 1'b0);
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    send_item(OP_COMMIT,    5'd0,  3'd0, 8'h00, 2'd0, 4'h0);
    send_item(OP_WRITE_COL, 5'd0,  3'd0, 8'hFF, 2'd0, 4'h0);
    send_item(OP_WRITE_COL, 5'd31, 3'd0, 8'h80, 2'd0, 4'h0);
    send_item(OP_WRITE_COL, 5'd7,  3'd0, 8'h01, 2'd0, 4'h0);
    send_item(OP_WRITE_COL, 5'd8,  3'd0, 8'h55, 2'd0, 4'h0);
    send_item(OP_SET_PIXEL, 5'd30, 3'd7, 8'h00, 2'd0, 4'h0);
    send_item(OP_SET_PIXEL, 5'd16, 3'd0, 8'h00, 2'd0, 4'h0);
    send_item(OP_COMMIT,    5'd0,  3'd0, 8'h00, 2'd0, 4'h0);
    send_item(OP_REG_ONE,   5'd0,  3'd0, 8'hFF, 2'd0, 4'hF);
    send_item(OP_REG_ONE,   5'd0,  3'd0, 8'h00, 2'd3, 4'h0);
    send_item(OP_REG_ALL,   5'd0,  3'd0, 8'h01, 2'd0, 4'hC);
    send_item(OP_RSVD6,     5'd31, 3'd7, 8'hFF, 2'd3, 4'hF);
    send_item(OP_RSVD7,     5'd31, 3'd7, 8'hFF, 2'd3, 4'hF);
    send_item(OP_CLEAR,     5'd0,  3'd0, 8'h00, 2'd0, 4'h0);
    send_item(OP_COMMIT,    5'd0,  3'd0, 8'h00, 2'd0, 4'h0);
    settle();

    set_config(3'd1, 1'b1);
    send_item(OP_WRITE_COL, 5'd7,  3'd0, 8'hFF, 2'd0, 4'h0);
    send_item(OP_WRITE_COL, 5'd0,  3'd0, 8'h81, 2'd0, 4'h0);
    send_item(OP_WRITE_COL, 5'd8,  3'd0, 8'hFF, 2'd0, 4'h0);
    send_item(OP_SET_PIXEL, 5'd31, 3'd3, 8'h00, 2'd0, 4'h0);
    send_item(OP_REG_ONE,   5'd0,  3'd0, 8'h12, 2'd1, 4'h3);
    send_item(OP_REG_ONE,   5'd0,  3'd0, 8'h3C, 2'd0, 4'h9);
    send_item(OP_REG_ALL,   5'd0,  3'd0, 8'h0F, 2'd0, 4'hA);
    send_item(OP_COMMIT,    5'd0,  3'd0, 8'h00, 2'd0, 4'h0);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      set_config(phase_dev[p], phase_rot[p]);
      quiet = (p >= PHASES - 2);
      if (p == 2) hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        tx_gaps   = !quiet && ((i / 15) % 3 != 2);
        rx_stalls = tx_gaps;
        send_random();
      end
      settle();
    end

    $display("run covered %0d input transfers, %0d output words, %0d register writes",
             sb.items_seen, sb.words_seen, cfg_writes);
    $display("chain lengths 0..7 requested, both rotate settings, %0d mismatches",
             sb.errors);
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
